// ===== sv/float_integer_converter_defines.svh =====
// Assertion macros shared by the converter checker.
`ifndef FLOAT_INTEGER_CONVERTER_DEFINES_SVH
`define FLOAT_INTEGER_CONVERTER_DEFINES_SVH
// Property that holds at every clock edge outside reset.
`define FIC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Same, but also checked during reset.
`define FIC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== sv/fic_pkg.sv =====
// Package with the command codes and the payload types of the converter.
`timescale 1ns / 1ps
package fic_pkg;
    typedef logic [1:0]  t_cmd;
    typedef logic [31:0] t_word;
    localparam t_cmd CMD_S2F = 2'd0;
    localparam t_cmd CMD_U2F = 2'd1;
    localparam t_cmd CMD_F2S = 2'd2;
    localparam t_cmd CMD_F2U = 2'd3;
    localparam int   EXP_BIAS = 127;
endpackage

// ===== sv/fic_int2flt.sv =====
// Integer to single-precision conversion with round to nearest even.
`timescale 1ns / 1ps
module fic_int2flt (
    input  fic_pkg::t_cmd  i_cmd,
    input  fic_pkg::t_word i_bits,
    output fic_pkg::t_word o_result
);
    import fic_pkg::*;
    logic        neg;
    logic [31:0] mag;
    logic [31:0] norm;
    logic [4:0]  top;
    logic [4:0]  lz;
    logic        found;
    logic [24:0] q;
    logic        guard;
    logic        sticky;
    logic [7:0]  ex;

    always_comb begin
        neg = (i_cmd == CMD_S2F) && i_bits[31];
        mag = neg ? (32'd0 - i_bits) : i_bits;
        lz = 5'd0;
        found = 1'b0;
        for (int k = 31; k >= 0; k--) begin
            if (!found && mag[k]) begin
                found = 1'b1;
                lz = 5'(31 - k);
            end
        end
        top = 5'd31 - lz;
        norm = mag << lz;
        // Bits below the 24 kept ones decide the rounding.
        guard = norm[7];
        sticky = |norm[6:0];
        q = {1'b0, norm[31:8]};
        if (guard && (sticky || q[0])) begin
            q = q + 25'd1;
        end
        ex = 8'(top) + 8'(EXP_BIAS);
        if (q[24]) begin
            ex = ex + 8'd1;
        end
        if (!found) begin
            o_result = 32'd0;
        end else begin
            o_result = {neg, ex, q[24] ? q[23:1] : q[22:0]};
        end
    end
endmodule

// ===== sv/fic_flt2int.sv =====
// Single precision to saturated 32-bit integer with round to nearest even.
`timescale 1ns / 1ps
module fic_flt2int (
    input  fic_pkg::t_cmd  i_cmd,
    input  fic_pkg::t_word i_bits,
    output fic_pkg::t_word o_result
);
    import fic_pkg::*;
    logic        neg;
    logic        want_signed;
    logic [7:0]  ef;
    logic [22:0] man;
    logic [32:0] mag;
    logic [55:0] wide;
    logic        guard;
    logic        sticky;
    logic        big;
    logic [4:0]  rsh;

    always_comb begin
        neg = i_bits[31];
        ef = i_bits[30:23];
        man = i_bits[22:0];
        want_signed = (i_cmd == CMD_F2S);
        big = 1'b0;
        mag = 33'd0;
        wide = 56'd0;
        guard = 1'b0;
        sticky = 1'b0;
        rsh = 5'd0;
        if (ef == 8'hFF) begin
            big = 1'b1;
        end else if (ef >= 8'd159) begin
            big = 1'b1;
        end else if (ef >= 8'd150) begin
            mag = 33'({1'b1, man}) << (ef - 8'd150);
        end else if (ef >= 8'd126) begin
            // Right shift by 150 - ef keeps integer bits; the rest rounds.
            rsh = 5'(8'd150 - ef);
            wide = {1'b1, man, 32'd0} >> rsh;
            mag = 33'(wide[55:32]);
            guard = wide[31];
            sticky = |wide[30:0];
            if (guard && (sticky || mag[0])) begin
                mag = mag + 33'd1;
            end
        end
        if (ef == 8'hFF && man != 23'd0) begin
            o_result = 32'd0;
        end else if (ef == 8'd0) begin
            o_result = 32'd0;
        end else if (want_signed) begin
            if (neg) begin
                o_result = (big || mag > 33'h080000000) ? 32'h80000000
                                                        : (32'd0 - mag[31:0]);
            end else begin
                o_result = (big || mag > 33'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
            end
        end else if (neg) begin
            o_result = 32'd0;
        end else begin
            o_result = (big || mag[32]) ? 32'hFFFFFFFF : mag[31:0];
        end
    end
endmodule

// ===== sv/float_integer_converter.sv =====
// Top level of the integer and single-precision converter.
// Path: the input register captures each transfer, and its conversion is held in the result register.
// Throughput: one item per cycle while results are taken, set by the single combinational pass between them.
// A stalled result holds; the input register refills when the result moves on.
// Reset (synchronous, active low) clears both valid flags; payloads are not reset.
`timescale 1ns / 1ps
module float_integer_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] operand_bits
    input  logic [31:0] s_axis_tdata,
    // [1:0] command
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] result_bits
    output logic [31:0] m_axis_tdata
);
    import fic_pkg::*;
    logic  r_in_valid, n_in_valid;
    t_cmd  r_cmd;
    t_word r_bits;
    logic  r_out_valid, n_out_valid;
    t_word r_result;
    t_word i2f_result;
    t_word f2i_result;
    logic  adv;

    fic_int2flt u_int2flt (.i_cmd(r_cmd), .i_bits(r_bits), .o_result(i2f_result));
    fic_flt2int u_flt2int (.i_cmd(r_cmd), .i_bits(r_bits), .o_result(f2i_result));

    assign adv = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata = r_result;

    always_comb begin
        n_in_valid = s_axis_tready ? s_axis_tvalid : r_in_valid;
        n_out_valid = adv ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_cmd <= s_axis_tuser;
            r_bits <= s_axis_tdata;
        end
        if (adv && r_in_valid) begin
            r_result <= r_cmd[1] ? f2i_result : i2f_result;
        end
    end
endmodule

// ===== sv/fic_checker.sv =====
// Port-level checker for the converter, bound to the top level.
`timescale 1ns / 1ps
`include "float_integer_converter_defines.svh"
module fic_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    `FIC_ASSERT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `FIC_ASSERT(a_ready, i_clk, i_rst_n, m_axis_tready |-> s_axis_tready, "input stalled while output drains")
    `FIC_ASSERT(a_out, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> $past(s_axis_tvalid, 2) || $past(s_axis_tvalid), "result without transfer")
    `FIC_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !m_axis_tvalid, "valid after reset")
endmodule

bind float_integer_converter fic_checker u_fic_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

// ===== dv/float_integer_converter_tb.sv =====
// Self-checking testbench for the integer and single-precision converter.
`timescale 1ns / 1ps
module float_integer_converter_tb;
    import fic_pkg::*;

    typedef struct packed {
        t_cmd  cmd;
        t_word operand;
        logic  has_result;
        t_word result;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [31:0] operand_bits
    logic [31:0] s_axis_tdata = '0;
    // [1:0] command
    logic [1:0]  s_axis_tuser = CMD_S2F;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [31:0] result_bits
    logic [31:0] m_axis_tdata;

    t_word expected_words[$];
    int    mismatch_count = 0;
    int    idle_cycles = 0;
    bit    sending_done = 1'b0;
    bit    long_hold_request = 1'b0;

    float_integer_converter u_top (.*);

    always #5 i_clk = ~i_clk;

    function automatic t_word int_to_single(input logic neg, input logic [31:0] mag);
        int           top;
        int           sh;
        logic [31:0]  q;
        logic [31:0]  rem;
        logic [31:0]  half;
        logic [7:0]   ex;
        if (mag == 0) return '0;
        top = 31;
        while (!mag[top]) top--;
        ex = 8'(top);
        if (top <= 23) begin
            q = mag << (23 - top);
        end else begin
            sh = top - 23;
            rem = mag & ((32'd1 << sh) - 32'd1);
            half = 32'd1 << (sh - 1);
            q = mag >> sh;
            if (rem > half || (rem == half && q[0])) q++;
            if (q == 32'h0100_0000) begin
                q = q >> 1;
                ex++;
            end
        end
        return {neg, ex + 8'd127, q[22:0]};
    endfunction

    function automatic t_word single_to_int(input t_word bits, input logic want_signed);
        logic        neg;
        logic [7:0]  ef;
        int          e;
        int          sh;
        logic [23:0] m;
        logic [63:0] mag;
        logic [31:0] rem;
        logic [31:0] half;
        logic [31:0] q;
        logic        big;
        neg = bits[31];
        ef = bits[30:23];
        big = 1'b0;
        mag = '0;
        if (ef == 8'hFF) begin
            if (bits[22:0] != 0) return '0;
            big = 1'b1;
        end else if (ef == 0) begin
            return '0;
        end else begin
            e = int'(ef) - EXP_BIAS;
            m = {1'b1, bits[22:0]};
            if (e >= 32) big = 1'b1;
            else if (e >= 23) mag = 64'(m) << (e - 23);
            else if (e >= -1) begin
                sh = 23 - e;
                rem = 32'(m) & ((32'd1 << sh) - 32'd1);
                half = 32'd1 << (sh - 1);
                q = 32'(m) >> sh;
                if (rem > half || (rem == half && q[0])) q++;
                mag = 64'(q);
            end
        end
        if (want_signed) begin
            if (neg) begin
                if (big || mag > 64'h8000_0000) return 32'h8000_0000;
                return -mag[31:0];
            end
            if (big || mag > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
            return mag[31:0];
        end
        if (neg) return '0;
        if (big || mag > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
        return mag[31:0];
    endfunction

    function automatic t_word convert(input t_cmd cmd, input t_word x);
        case (cmd)
            CMD_S2F: return int_to_single(x[31], x[31] ? -x : x);
            CMD_U2F: return int_to_single(1'b0, x);
            CMD_F2S: return single_to_int(x, 1'b1);
            default: return single_to_int(x, 1'b0);
        endcase
    endfunction

    // Directed rows; a typed-in result is what the block must give, the others use the predictor.
    t_row directed_rows[] = '{
        '{CMD_S2F, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{CMD_S2F, 32'h0000_0001, 1'b1, 32'h3F80_0000},
        '{CMD_S2F, 32'hFFFF_FFFF, 1'b1, 32'hBF80_0000},
        '{CMD_S2F, 32'h8000_0000, 1'b1, 32'hCF00_0000},
        '{CMD_S2F, 32'h7FFF_FFFF, 1'b1, 32'h4F00_0000},
        '{CMD_S2F, 32'h0100_0003, 1'b0, 32'h0},
        '{CMD_U2F, 32'hFFFF_FFFF, 1'b1, 32'h4F80_0000},
        '{CMD_U2F, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{CMD_U2F, 32'h0100_0001, 1'b0, 32'h0},
        '{CMD_F2S, 32'h0000_0000, 1'b1, 32'h0000_0000},
        '{CMD_F2S, 32'h8000_0000, 1'b1, 32'h0000_0000},
        '{CMD_F2S, 32'h0000_0001, 1'b1, 32'h0000_0000},
        '{CMD_F2S, 32'hBF00_0000, 1'b1, 32'h0000_0000},
        '{CMD_F2S, 32'h3FC0_0000, 1'b1, 32'h0000_0002},
        '{CMD_F2S, 32'h4020_0000, 1'b1, 32'h0000_0002},
        '{CMD_F2S, 32'h7FC0_0000, 1'b1, 32'h0000_0000},
        '{CMD_F2S, 32'h7F80_0000, 1'b1, 32'h7FFF_FFFF},
        '{CMD_F2S, 32'hFF80_0000, 1'b1, 32'h8000_0000},
        '{CMD_F2S, 32'hCF00_0000, 1'b1, 32'h8000_0000},
        '{CMD_F2S, 32'h4F00_0000, 1'b1, 32'h7FFF_FFFF},
        '{CMD_F2U, 32'h4F80_0000, 1'b1, 32'hFFFF_FFFF},
        '{CMD_F2U, 32'h4F7F_FFFF, 1'b0, 32'h0},
        '{CMD_F2U, 32'hFF80_0000, 1'b1, 32'h0000_0000},
        '{CMD_F2U, 32'hBF80_0000, 1'b1, 32'h0000_0000},
        '{CMD_F2U, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000}
    };

    // Called at a falling edge; valid stays high after the transfer so that
    // items with no gap follow back to back.
    task automatic send_item(input t_cmd cmd, input t_word x, input int gap,
                             input t_word want);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= x;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_words.push_back(want);
        @(negedge i_clk);
    endtask

    function automatic t_word random_operand(input t_cmd cmd);
        t_word x;
        x = $urandom;
        case ($urandom_range(0, 5))
            0: x = x >> $urandom_range(0, 31);
            1: if (cmd >= CMD_F2S) x[30:23] = 8'($urandom_range(118, 160));
            2: if (cmd >= CMD_F2S) x[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            3: if (cmd >= CMD_F2S) x = {x[31], 8'(126 + $urandom_range(0, 24)),
                   x[22:0] & ~(23'h7F_FFFF >> $urandom_range(0, 23))};
            default: ;
        endcase
        return x;
    endfunction

    initial begin
        t_cmd  cmd;
        t_word x;
        t_word want;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[i]) begin
            want = directed_rows[i].has_result ? directed_rows[i].result
                 : convert(directed_rows[i].cmd, directed_rows[i].operand);
            send_item(directed_rows[i].cmd, directed_rows[i].operand, 0, want);
        end
        for (int n = 0; n < 1450; n++) begin
            if (n == 300) long_hold_request = 1'b1;
            if (n == 700) begin
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
                while (expected_words.size() != 0) @(negedge i_clk);
            end
            cmd = t_cmd'($urandom_range(0, 3));
            x = random_operand(cmd);
            send_item(cmd, x, (n > 900 && n < 1100) ? 0 : $urandom_range(0, 17),
                      convert(cmd, x));
        end
        s_axis_tvalid <= 1'b0;
        sending_done = 1'b1;
    end

    // Receiver pacing; one long hold-off lets the pipeline fill and stall the input.
    initial begin
        int wait_cycles;
        forever begin
            wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (long_hold_request) begin
                long_hold_request = 1'b0;
                wait_cycles = 60;
            end
            if (wait_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transfer: %h", m_axis_tdata);
            end else begin
                if (m_axis_tdata !== expected_words[0]) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %h, got %h",
                                 expected_words[0], m_axis_tdata);
                end
                void'(expected_words.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (sending_done && expected_words.size() == 0);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("float_integer_converter_tb: done, clean");
        else
            $display("float_integer_converter_tb: done, errors");
        $finish;
    end

    initial begin
        wait (idle_cycles >= 2000);
        $display("float_integer_converter_tb: done, errors");
        $finish;
    end
endmodule
